>>> src/lbb_pkg.sv
package lbb_pkg;

  // Effect mode codes
  localparam logic [1:0] MODE_STEADY  = 2'd0;
  localparam logic [1:0] MODE_FLASH   = 2'd1;
  localparam logic [1:0] MODE_BREATHE = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LVL_HIGH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LVL_LOW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_PER  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP      = 3'd4;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned LVL_FIELD_W = 7;
  localparam int unsigned HP_W = 16;

  localparam logic [HP_W-1:0]        HALF_PER_RST = 16'd500;
  localparam logic [LVL_FIELD_W-1:0] STEP_RST     = 7'd1;

  typedef struct packed {
    logic [1:0]             effect_mode;
    logic [LVL_FIELD_W-1:0] level_high;
    logic [LVL_FIELD_W-1:0] level_low;
    logic [HP_W-1:0]        half_period_ticks;
    logic [LVL_FIELD_W-1:0] breathe_step;
  } lbb_cfg_t;

  typedef struct packed {
    logic [LVL_FIELD_W-1:0] drive_level;
    logic [LVL_FIELD_W-1:0] brightness;
    logic                   write_strobe;
  } lbb_res_t;

endpackage

>>> src/lbb_cfg_regs.sv
module lbb_cfg_regs
  import lbb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output lbb_cfg_t              cfg
);

  lbb_cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        REG_MODE:     cfg_nxt.effect_mode       = wr_data[1:0];
        REG_LVL_HIGH: cfg_nxt.level_high        = wr_data[LVL_FIELD_W-1:0];
        REG_LVL_LOW:  cfg_nxt.level_low         = wr_data[LVL_FIELD_W-1:0];
        REG_HALF_PER: cfg_nxt.half_period_ticks = wr_data[HP_W-1:0];
        REG_STEP:     cfg_nxt.breathe_step      = wr_data[LVL_FIELD_W-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.effect_mode       <= MODE_STEADY;
      cfg_r.level_high        <= '0;
      cfg_r.level_low         <= '0;
      cfg_r.half_period_ticks <= HALF_PER_RST;
      cfg_r.breathe_step      <= STEP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> src/lbb_effect_core.sv
module lbb_effect_core
  import lbb_pkg::*;
#(
  parameter int LEVEL_MAX  = 100,
  parameter int TIMER_BITS = 16,
  parameter int LW         = $clog2(LEVEL_MAX + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  lbb_cfg_t      cfg,
  input  logic          fire,
  input  logic          tick,
  output lbb_res_t      res,
  output logic [LW-1:0] level
);

  // compute width: wide enough for 7-bit fields and the level, plus sum headroom
  localparam int CW = ((LW > LVL_FIELD_W) ? LW : LVL_FIELD_W) + 2;
  localparam int TW = (TIMER_BITS > HP_W) ? TIMER_BITS : HP_W;

  logic [LW-1:0]         level_r, level_nxt;
  logic [TIMER_BITS-1:0] elapsed_r, elapsed_nxt;
  logic                  falling_r, falling_nxt;

  logic [CW-1:0]         lim, a_x, b_x, hi, lo, cur_x, step_x, lv, sum, rise, fall;
  logic [CW-1:0]         new_x;
  logic [TIMER_BITS-1:0] ela_inc;
  logic                  due, strobe;

  always_comb begin
    lim    = CW'(LEVEL_MAX);
    a_x    = (CW'(cfg.level_high) > lim) ? lim : CW'(cfg.level_high);
    b_x    = (CW'(cfg.level_low)  > lim) ? lim : CW'(cfg.level_low);
    hi     = (a_x > b_x) ? a_x : b_x;
    lo     = (a_x > b_x) ? b_x : a_x;
    cur_x  = CW'(level_r);
    step_x = CW'(cfg.breathe_step);

    // saturating tick count
    ela_inc = elapsed_r;
    if (tick && (elapsed_r != {TIMER_BITS{1'b1}}))
      ela_inc = elapsed_r + TIMER_BITS'(1);
    due = TW'(ela_inc) >= TW'(cfg.half_period_ticks);

    sum  = cur_x + step_x;
    rise = (sum > lim) ? lim : sum;
    fall = (cur_x > step_x) ? (cur_x - step_x) : '0;
    lv   = falling_r ? fall : rise;

    new_x       = cur_x;
    elapsed_nxt = ela_inc;
    falling_nxt = falling_r;
    strobe      = 1'b0;

    case (cfg.effect_mode)
      MODE_STEADY: begin
        if (a_x != cur_x) begin
          new_x       = a_x;
          elapsed_nxt = '0;
          strobe      = 1'b1;
        end
      end
      MODE_FLASH: begin
        if (due) begin
          new_x       = ((cur_x << 1) >= (hi + lo)) ? lo : hi;
          elapsed_nxt = '0;
          strobe      = 1'b1;
        end
      end
      MODE_BREATHE: begin
        if (due) begin
          new_x       = lv;
          elapsed_nxt = '0;
          strobe      = 1'b1;
          if (lv >= hi)
            falling_nxt = 1'b1;
          else if (lv <= lo)
            falling_nxt = 1'b0;
        end
      end
      default: begin
        // unused mode: only the tick count moves
      end
    endcase

    level_nxt        = LW'(new_x);
    res.drive_level  = LVL_FIELD_W'(lim - new_x);
    res.brightness   = LVL_FIELD_W'(new_x);
    res.write_strobe = strobe;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r   <= '0;
      elapsed_r <= '0;
      falling_r <= 1'b0;
    end else if (fire) begin
      level_r   <= level_nxt;
      elapsed_r <= elapsed_nxt;
      falling_r <= falling_nxt;
    end
  end

  assign level = level_r;

endmodule

>>> src/led_blink_breathe_controller.sv
// Channel  | Dir | Ports                                | Payload
// in_      | in  | in_tvalid/in_tready/in_tdata[7:0]    | tick
// out_     | out | out_tvalid/out_tready/out_tdata[15:0]| drive_level, brightness, strobe
// cfg_     | in  | cfg_valid/cfg_ready/cfg_index/cfg_data| register write request
//
// One request per cycle sustained while the output is not stalled. The
// request lands in the input register when it is accepted; the effect logic
// runs in one pass and loads the output register when the request advances.
// Reset (rst_n low, synchronous) clears the level, tick counter, ramp direction
// and both valid flags, and loads the register defaults.
// A stalled output holds its result; the input register keeps one request
// waiting and in_tready drops only when both registers are full and stalled.
// Config writes are always taken (cfg_ready is tied high).
module led_blink_breathe_controller
  import lbb_pkg::*;
#(
  parameter int LEVEL_MAX  = 100,
  parameter int TIMER_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [0] tick, [7:1] zero
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [15:0]           out_tdata,  // [6:0] drive_level, [13:7] brightness,
                                            // [14] write_strobe, [15] zero
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int LW = $clog2(LEVEL_MAX + 1);

  lbb_cfg_t cfg;
  lbb_res_t res;
  logic [LW-1:0] level;

  // input register
  logic s1_valid_r, s1_valid_nxt;
  logic s1_tick_r;
  logic s1_adv;

  // output register
  logic     out_valid_r, out_valid_nxt;
  lbb_res_t out_res_r;

  logic in_acc;

  assign cfg_ready = 1'b1;

  lbb_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // the held request is processed when the output register is free or draining
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  lbb_effect_core #(
    .LEVEL_MAX  (LEVEL_MAX),
    .TIMER_BITS (TIMER_BITS),
    .LW         (LW)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .fire  (s1_adv),
    .tick  (s1_tick_r),
    .res   (res),
    .level (level)
  );

  always_comb begin
    s1_valid_nxt  = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
    out_valid_nxt = s1_adv ? 1'b1 : ((out_tready) ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc)
      s1_tick_r <= in_tdata[0];
    if (s1_adv)
      out_res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_res_r.write_strobe, out_res_r.brightness,
                       out_res_r.drive_level};

`ifndef SYNTHESIS
  // the level never leaves 0..LEVEL_MAX
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(level) <= 32'(LEVEL_MAX))
    else $error("brightness level above LEVEL_MAX");

  // drive and brightness are complements when neither wraps the 7-bit field
  a_drive_compl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((LEVEL_MAX > 127) ||
      (32'(out_tdata[6:0]) + 32'(out_tdata[13:7]) == 32'(LEVEL_MAX))))
    else $error("drive level does not complement brightness");

  // an unused mode never strobes
  a_unused_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && cfg.effect_mode != MODE_STEADY && cfg.effect_mode != MODE_FLASH &&
     cfg.effect_mode != MODE_BREATHE) |=> !out_tdata[14])
    else $error("strobe in unused mode");

  // a held request blocks new input only while the output stalls
  a_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |-> (!in_tready && out_tvalid && !out_tready))
    else $error("input blocked without output stall");
`endif

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;
  import lbb_pkg::*;

  localparam int LEVEL_TOP   = 100;   // brightness ceiling of the block
  localparam int QUIET_LIMIT = 2000;  // cycles with no request moving on any channel
  localparam int REPORT_MAX  = 10;
  localparam int REG_COUNT   = 5;     // indexes at and above this decode to nothing
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [HP_W-1:0] TICKS_SAT = '1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = '0;     // [0] tick, [7:1] zero
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [15:0]           out_tdata;         // [6:0] drive_level, [13:7] brightness,
                                            // [14] write_strobe, [15] zero
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow copy of the register file, loaded as each write request is taken.
  logic [1:0]             eff_mode   = MODE_STEADY;
  logic [LVL_FIELD_W-1:0] lvl_hi_reg = '0;
  logic [LVL_FIELD_W-1:0] lvl_lo_reg = '0;
  logic [HP_W-1:0]        half_reg   = HALF_PER_RST;
  logic [LVL_FIELD_W-1:0] step_reg   = STEP_RST;

  // Shadow of the effect state: brightness, tick counter, ramp direction.
  logic [LVL_FIELD_W-1:0] lvl_now    = '0;
  logic [HP_W-1:0]        tick_count = '0;
  logic                   ramp_down  = 1'b0;

  lbb_res_t led_results_due[$];   // one entry per accepted tick request, oldest first

  int mismatch_count = 0;
  int quiet_cycles   = 0;
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int holdoff_cycles  = 0;        // nonzero: receiver drops tready for that many cycles

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  led_blink_breathe_controller uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Next LED state for one tick request; updates the shadow state.
  function automatic lbb_res_t led_effect_step(input bit tick);
    int a;
    int b;
    int top;
    int bot;
    int lv;
    bit due;
    lbb_res_t r;
    a = (lvl_hi_reg > LEVEL_TOP) ? LEVEL_TOP : int'(lvl_hi_reg);
    b = (lvl_lo_reg > LEVEL_TOP) ? LEVEL_TOP : int'(lvl_lo_reg);
    top = (a > b) ? a : b;
    bot = (a > b) ? b : a;
    r.write_strobe = 1'b0;
    // counter saturates rather than wrapping
    if (tick && tick_count != TICKS_SAT) tick_count = tick_count + 1'b1;
    due = (tick_count >= half_reg);
    case (eff_mode)
      MODE_STEADY: begin
        if (a != int'(lvl_now)) begin
          lvl_now = LVL_FIELD_W'(a);
          tick_count = '0;
          r.write_strobe = 1'b1;
        end
      end
      MODE_FLASH: begin
        if (due) begin
          tick_count = '0;
          lvl_now = (2 * int'(lvl_now) >= top + bot) ? LVL_FIELD_W'(bot) : LVL_FIELD_W'(top);
          r.write_strobe = 1'b1;
        end
      end
      MODE_BREATHE: begin
        if (due) begin
          tick_count = '0;
          lv = int'(lvl_now);
          if (ramp_down) begin
            lv = (lv > int'(step_reg)) ? lv - int'(step_reg) : 0;
          end else begin
            lv = lv + int'(step_reg);
            if (lv > LEVEL_TOP) lv = LEVEL_TOP;
          end
          // turn round at either bound; inside the band keep direction
          if (lv >= top) ramp_down = 1'b1;
          else if (lv <= bot) ramp_down = 1'b0;
          lvl_now = LVL_FIELD_W'(lv);
          r.write_strobe = 1'b1;
        end
      end
      default: ;  // unused mode: only the counter moves
    endcase
    r.brightness  = lvl_now;
    r.drive_level = LVL_FIELD_W'(LEVEL_TOP - int'(lvl_now));  // active-low pin
    return r;
  endfunction

  // One tick request. Leaves tvalid high so back-to-back requests stream;
  // wait_idle() drops it.
  task automatic send_tick(input bit tick);
    if (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, tick};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    led_results_due.push_back(led_effect_step(tick));
  endtask

  task automatic send_random_ticks(input int count);
    repeat (count) send_tick($urandom_range(0, 99) < 70);
  endtask

  // Stop offering, let every outstanding result drain, then allow the
  // two-stage pipe to settle before anything touches the registers.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (led_results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_MODE:     eff_mode   = data[1:0];
      REG_LVL_HIGH: lvl_hi_reg = data[LVL_FIELD_W-1:0];
      REG_LVL_LOW:  lvl_lo_reg = data[LVL_FIELD_W-1:0];
      REG_HALF_PER: half_reg   = data[HP_W-1:0];
      REG_STEP:     step_reg   = data[LVL_FIELD_W-1:0];
      default: ;  // no register behind this index
    endcase
  endtask

  // Full register load; raw 16-bit words so upper bits get exercised.
  task automatic apply_config(input logic [15:0] mode_w, input logic [15:0] hi_w,
                              input logic [15:0] lo_w, input logic [15:0] half_w,
                              input logic [15:0] step_w);
    wait_idle();
    write_reg(REG_MODE, mode_w);
    write_reg(REG_LVL_HIGH, hi_w);
    write_reg(REG_LVL_LOW, lo_w);
    write_reg(REG_HALF_PER, half_w);
    write_reg(REG_STEP, step_w);
    cfg_valid <= 1'b0;
  endtask

  // Steady mode: reset defaults, over-range target clamps, target change writes once.
  task automatic test_steady();
    send_tick(1'b1);
    send_tick(1'b0);
    apply_config(16'(MODE_STEADY), 16'hFFFF, 16'd0, HALF_PER_RST, 16'(STEP_RST));
    send_tick(1'b0);
    send_tick(1'b1);
    apply_config(16'(MODE_STEADY), 16'd0, 16'd100, 16'd0, 16'd0);
    send_tick(1'b1);
    send_tick(1'b1);
  endtask

  // Unused mode: level frozen, no strobe.
  task automatic test_unused_mode();
    apply_config({14'h3FFF, MODE_UNUSED}, 16'd60, 16'd10, 16'd0, 16'd5);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
  endtask

  task automatic test_flash();
    // zero half period: toggles on every request, tick or not
    apply_config(16'(MODE_FLASH), 16'd80, 16'd20, 16'd0, 16'd1);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    // writes to indexes past the register list must not alias onto real registers
    wait_idle();
    for (int k = REG_COUNT; k < 2 ** CFG_IDX_W; k++) write_reg(CFG_IDX_W'(k), 16'hFFFF);
    cfg_valid <= 1'b0;
    send_tick(1'b0);
    send_tick(1'b1);
    // equal levels hold, rewritten every half period
    apply_config(16'(MODE_FLASH), 16'hFF9E, 16'd30, 16'd2, 16'd1);
    repeat (4) send_tick(1'b1);
    send_tick(1'b0);
    // levels given in reverse order
    apply_config(16'(MODE_FLASH), 16'd0, 16'd100, 16'd1, 16'd0);
    repeat (3) send_tick(1'b1);
  endtask

  task automatic test_breathe();
    apply_config(16'(MODE_BREATHE), 16'd90, 16'd10, 16'd0, 16'd37);
    repeat (6) send_tick(1'b1);
    // zero step: level holds, direction still tracks bounds
    apply_config(16'(MODE_BREATHE), 16'd10, 16'd90, 16'd1, 16'd0);
    repeat (3) send_tick(1'b1);
    // park at full brightness, then breathe in a band below it
    apply_config(16'(MODE_STEADY), 16'd100, 16'd0, 16'd0, 16'd1);
    send_tick(1'b0);
    apply_config(16'(MODE_BREATHE), 16'd40, 16'd20, 16'd0, 16'd15);
    repeat (5) send_tick(1'b0);
    // largest step, saturating at both ends
    apply_config(16'(MODE_BREATHE), 16'hFFFF, 16'd0, 16'd0, 16'h007F);
    repeat (3) send_tick(1'b1);
    // equal levels: bounces about the level
    apply_config(16'(MODE_BREATHE), 16'd50, 16'd50, 16'd0, 16'd3);
    repeat (3) send_tick(1'b1);
  endtask

  // Longest half period: ticks pile up in unused mode, flash must still hold off.
  task automatic test_long_half_period();
    apply_config(16'(MODE_UNUSED), 16'd70, 16'd10, 16'hFFFF, 16'd1);
    repeat (40) send_tick(1'b1);
    apply_config(16'(MODE_FLASH), 16'd70, 16'd10, 16'hFFFF, 16'd1);
    send_tick(1'b0);
    send_tick(1'b1);
  endtask

  task automatic test_backpressure();
    apply_config(16'(MODE_BREATHE), 16'd100, 16'd0, 16'd1, 16'd9);
    // receiver goes dark; block fills and must push back on the sender
    holdoff_cycles = 300;
    send_random_ticks(40);
    // sender pauses until every result is home
    wait_idle();
    repeat (20) send_tick(1'b1);
  endtask

  task automatic test_random();
    int pick;
    logic [1:0] mode;
    logic [15:0] half_w;
    logic [15:0] step_w;
    for (int phase = 0; phase < 4; phase++) begin
      wait_idle();
      case (phase)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 74; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin sender_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      repeat (4) begin
        pick = $urandom_range(0, 9);
        mode = (pick == 0) ? MODE_STEADY : (pick < 5) ? MODE_FLASH :
               (pick < 9) ? MODE_BREATHE : MODE_UNUSED;
        // mostly short half periods so effects fire often
        half_w = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
        step_w = {9'($urandom),
                  ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(0, 20))};
        apply_config({14'($urandom), mode}, 16'($urandom), 16'($urandom), half_w, step_w);
        send_random_ticks(105);
      end
    end
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
  endtask

  // Result side: random stalls per phase, or a long counted hold-off on request.
  always begin
    @(posedge clk);
    if (holdoff_cycles != 0) begin
      out_tready <= 1'b0;
      repeat (holdoff_cycles) @(posedge clk);
      holdoff_cycles = 0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin : result_check
    lbb_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (led_results_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("unexpected result: drive %0d level %0d strobe %0d",
                   out_tdata[6:0], out_tdata[13:7], out_tdata[14]);
      end else begin
        want = led_results_due.pop_front();
        if (out_tdata[6:0] !== want.drive_level || out_tdata[13:7] !== want.brightness ||
            out_tdata[14] !== want.write_strobe) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("mismatch: want drive %0d level %0d strobe %0d, got %0d %0d %0d",
                     want.drive_level, want.brightness, want.write_strobe,
                     out_tdata[6:0], out_tdata[13:7], out_tdata[14]);
        end
      end
    end
  end

  // Watchdog: nothing moving on any channel for too long means a hang.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_steady();
    test_unused_mode();
    test_flash();
    test_breathe();
    test_long_half_period();
    test_backpressure();
    test_random();
    wait_idle();
    repeat (6) @(posedge clk);
    if (mismatch_count == 0 && led_results_due.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
